/* sv/rstlb_pkg.sv */
package rstlb_pkg;

  localparam int SetsDef  = 16;
  localparam int WaysDef  = 4;
  localparam int CoresDef = 4;

  localparam int TagW    = 52;
  localparam int FrameW  = 36;
  localparam int CoreW   = 2;
  localparam int CoreIds = 4;
  localparam int KeyW    = 64;
  localparam int ThrW    = 16;
  localparam int EpochW  = 16;
  localparam int CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY    = 2'd0,
    CFG_THR    = 2'd1,
    CFG_SHARED = 2'd2
  } cfg_idx_e;

  localparam logic [KeyW-1:0] KeyRst = 64'h0011223344556677;
  localparam logic [ThrW-1:0] ThrRst = 16'd16;
  localparam logic [KeyW-1:0] Rc0    = 64'h13198a2e03707344;
  localparam logic [KeyW-1:0] Rc1    = 64'ha4093822299f31d0;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [FrameW-1:0] frame;
    logic [CoreW-1:0]  owner;
    logic              dirty;
  } entry_t;

  localparam logic [15:0] MatA [16] = '{
    16'h0111, 16'h2220, 16'h4404, 16'h8088, 16'h1011, 16'h0222, 16'h4440, 16'h8808,
    16'h1101, 16'h2022, 16'h0444, 16'h8880, 16'h1110, 16'h2202, 16'h4044, 16'h0888};
  localparam logic [15:0] MatB [16] = '{
    16'h1110, 16'h2202, 16'h4044, 16'h0888, 16'h0111, 16'h2220, 16'h4404, 16'h8088,
    16'h1011, 16'h0222, 16'h4440, 16'h8808, 16'h1101, 16'h2022, 16'h0444, 16'h8880};
  localparam logic [3:0] Sbox [16] = '{
    4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4};

  function automatic logic [15:0] mat_mul16(input logic [15:0] v, input logic use_b);
    logic [15:0] r;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      if (v[b]) begin
        r = r ^ (use_b ? MatB[b] : MatA[b]);
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] layer_sub(input logic [63:0] v);
    logic [63:0] r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = Sbox[v[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] layer_mix(input logic [63:0] v);
    return {mat_mul16(v[63:48], 1'b0), mat_mul16(v[47:32], 1'b1),
            mat_mul16(v[31:16], 1'b1), mat_mul16(v[15:0], 1'b0)};
  endfunction

  function automatic logic [63:0] cipher_round(input logic [63:0] x, input logic [63:0] k,
                                               input logic [1:0] rnd);
    logic [63:0] r;
    case (rnd)
      2'd0:    r = layer_sub(layer_mix(x ^ k ^ Rc0));
      2'd1:    r = layer_sub(layer_mix(x ^ k ^ Rc1));
      default: r = layer_mix(layer_sub(x ^ k));
    endcase
    return r;
  endfunction

endpackage

/* sv/rstlb_cipher.sv */
module rstlb_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] text_i,
  input  logic [63:0] key_i,
  output logic        done_o,
  output logic [63:0] text_o
);

  localparam logic [1:0] LastRnd = 2'd2;

  logic        busy_q, done_q;
  logic [1:0]  rnd_q;
  logic [63:0] x_q, key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 2'd1;
        if (rnd_q == LastRnd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // one round per cycle through the shared round unit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= text_i;
      key_q <= key_i;
    end else if (busy_q) begin
      x_q <= rstlb_pkg::cipher_round(x_q, key_q, rnd_q);
    end
  end

  assign done_o = done_q;
  assign text_o = x_q;

endmodule

/* sv/rstlb_way.sv */
module rstlb_way #(
  parameter int SETS = rstlb_pkg::SetsDef,
  parameter int WAYS = rstlb_pkg::WaysDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(SETS)-1:0]           rd_set_i,
  input  logic                              ent_we_i,
  input  logic [$clog2(SETS)-1:0]           wr_set_i,
  input  rstlb_pkg::entry_t                 wr_entry_i,
  input  logic [$clog2(SETS)-1:0]           rank_set_i,
  input  logic                              rank_we_i,
  input  logic [$clog2(WAYS+1)-1:0]         rank_wdata_i,
  output logic                              rd_valid_o,
  output rstlb_pkg::entry_t                 rd_entry_o,
  output logic [$clog2(WAYS+1)-1:0]         rank_o
);

  localparam int RankW = $clog2(WAYS+1);

  logic [SETS-1:0]   valid_q;
  logic [RankW-1:0]  rank_q [SETS];
  rstlb_pkg::entry_t mem_q [SETS];
  rstlb_pkg::entry_t rd_entry_q;
  logic              rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      for (int s = 0; s < SETS; s++) begin
        rank_q[s] <= RankW'(WAYS);
      end
    end else begin
      if (ent_we_i) begin
        valid_q[wr_set_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_set_i];
      end
      if (rank_we_i) begin
        rank_q[rank_set_i] <= rank_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      mem_q[wr_set_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_set_i];
    end
  end

  assign rd_valid_o = rd_valid_q;
  assign rd_entry_o = rd_entry_q;
  assign rank_o     = rank_q[rank_set_i];

endmodule

/* sv/randomized_skewed_tlb.sv */
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_ready_o | kind, page_number, new_frame, write_access, core
// out     | output    | out_valid_o/out_ready_i | hit, frame, rerandomized
// cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
// a lookup hit or an install goes through these steps from accept to result beat:
// 3 cipher rounds on the shared round unit, index latch, bank read, tag compare and fill,
// rank update (hits and installs only), result load
// in_ready_o is high only while the sequencer is idle, so the next beat is taken in the cycle
// after the result load at the earliest; a held result stalls the sequencer in its last state
// reset clears valid bits, miss counts and epochs and sets every rank to least recent
module randomized_skewed_tlb #(
  parameter int SETS  = rstlb_pkg::SetsDef,
  parameter int WAYS  = rstlb_pkg::WaysDef,
  parameter int CORES = rstlb_pkg::CoresDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [51:0] page_number_i,
  input  logic [35:0] new_frame_i,
  input  logic        write_access_i,
  input  logic [1:0]  core_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [35:0] frame_o,
  output logic        rerandomized_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i
);

  localparam int IW    = $clog2(SETS);
  localparam int RankW = $clog2(WAYS+1);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CIPH, S_READ, S_EVAL, S_ROW, S_FIN
  } state_e;

  state_e state_q;

  logic [63:0] key_q;
  logic [15:0] thr_q;
  logic        shared_q;
  logic [15:0] miss_cnt_q [rstlb_pkg::CoreIds];
  logic [15:0] epoch_q    [rstlb_pkg::CoreIds];

  logic        kind_q, wr_q;
  logic [51:0] page_q;
  logic [35:0] nframe_q;
  logic [1:0]  core_q;
  logic [IW-1:0]    idx_q [WAYS];
  logic [IW-1:0]    s_q;
  logic [WW-1:0]    tgt_q;
  logic [RankW-1:0] old_q;

  logic        res_hit_q, res_rer_q;
  logic [35:0] res_frame_q;
  logic        out_valid_q, hit_q, rer_q;
  logic [35:0] frame_q;

  logic        start;
  logic        ciph_done;
  logic [63:0] ciph_text;
  logic [63:0] ciph_key;

  logic                 way_valid [WAYS];
  rstlb_pkg::entry_t    way_entry [WAYS];
  logic [RankW-1:0]     way_rank  [WAYS];
  logic [RankW-1:0]     way_rank_new [WAYS];
  rstlb_pkg::entry_t    new_entry;

  logic          hit_any, vic_found;
  logic [WW-1:0] hit_way, vic_way;
  logic [15:0]   cnt_inc;

  assign in_ready_o = (state_q == S_IDLE);
  assign start      = in_valid_i && in_ready_o && (32'(core_i) < CORES);
  assign ciph_key   = key_q ^ 64'(core_i) ^ 64'(epoch_q[core_i]);
  assign cnt_inc    = miss_cnt_q[core_q] + 16'd1;

  assign new_entry.tag   = page_q;
  assign new_entry.frame = nframe_q;
  assign new_entry.owner = core_q;
  assign new_entry.dirty = wr_q;

  rstlb_cipher u_cipher (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .text_i (64'(page_number_i)),
    .key_i  (ciph_key),
    .done_o (ciph_done),
    .text_o (ciph_text)
  );

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    rstlb_way #(.SETS(SETS), .WAYS(WAYS)) u_way (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .rd_en_i     (state_q == S_READ),
      .rd_set_i    (idx_q[w]),
      .ent_we_i    ((state_q == S_EVAL) && kind_q && (vic_way == WW'(w))),
      .wr_set_i    (idx_q[w]),
      .wr_entry_i  (new_entry),
      .rank_set_i  ((state_q == S_ROW) ? s_q : idx_q[w]),
      .rank_we_i   (state_q == S_ROW),
      .rank_wdata_i(way_rank_new[w]),
      .rd_valid_o  (way_valid[w]),
      .rd_entry_o  (way_entry[w]),
      .rank_o      (way_rank[w])
    );
  end

  // touched way goes to most recent, only more recent ones age
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (tgt_q == WW'(w)) begin
        way_rank_new[w] = RankW'(1);
      end else if (way_rank[w] < old_q && way_rank[w] < RankW'(WAYS)) begin
        way_rank_new[w] = way_rank[w] + RankW'(1);
      end else begin
        way_rank_new[w] = way_rank[w];
      end
    end
  end

  always_comb begin
    logic [RankW-1:0] best;
    hit_any   = 1'b0;
    hit_way   = '0;
    vic_found = 1'b0;
    vic_way   = '0;
    best      = way_rank[0];
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && way_valid[w] && way_entry[w].tag == page_q &&
          (!shared_q || way_entry[w].owner == core_q)) begin
        hit_any = 1'b1;
        hit_way = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!vic_found && !way_valid[w]) begin
        vic_found = 1'b1;
        vic_way   = WW'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!vic_found && way_rank[w] == RankW'(WAYS)) begin
        vic_found = 1'b1;
        vic_way   = WW'(w);
      end
    end
    if (!vic_found) begin
      for (int w = 1; w < WAYS; w++) begin
        if (way_rank[w] > best) begin
          best    = way_rank[w];
          vic_way = WW'(w);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      key_q       <= rstlb_pkg::KeyRst;
      thr_q       <= rstlb_pkg::ThrRst;
      shared_q    <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      rer_q       <= 1'b0;
      frame_q     <= '0;
      for (int c = 0; c < rstlb_pkg::CoreIds; c++) begin
        miss_cnt_q[c] <= '0;
        epoch_q[c]    <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (rstlb_pkg::cfg_idx_e'(cfg_idx_i))
          rstlb_pkg::CFG_KEY:    key_q    <= cfg_data_i;
          rstlb_pkg::CFG_THR:    thr_q    <= cfg_data_i[15:0];
          rstlb_pkg::CFG_SHARED: shared_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q      <= kind_i;
            page_q      <= page_number_i;
            nframe_q    <= new_frame_i;
            wr_q        <= write_access_i;
            core_q      <= core_i;
            res_hit_q   <= 1'b0;
            res_rer_q   <= 1'b0;
            res_frame_q <= '0;
            state_q     <= start ? S_CIPH : S_FIN;
          end
        end
        S_CIPH: begin
          if (ciph_done) begin
            for (int w = 0; w < WAYS; w++) begin
              idx_q[w] <= ciph_text[4*(w%16) +: IW];
            end
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          if (kind_q) begin
            s_q     <= idx_q[vic_way];
            tgt_q   <= vic_way;
            old_q   <= way_rank[vic_way];
            state_q <= S_ROW;
          end else if (hit_any) begin
            s_q         <= idx_q[hit_way];
            tgt_q       <= hit_way;
            old_q       <= way_rank[hit_way];
            res_hit_q   <= 1'b1;
            res_frame_q <= way_entry[hit_way].frame;
            state_q     <= S_ROW;
          end else begin
            if (cnt_inc >= thr_q) begin
              epoch_q[core_q]    <= epoch_q[core_q] + 16'd1;
              miss_cnt_q[core_q] <= '0;
              res_rer_q          <= 1'b1;
            end else begin
              miss_cnt_q[core_q] <= cnt_inc;
            end
            state_q <= S_FIN;
          end
        end
        S_ROW: begin
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            hit_q       <= res_hit_q;
            frame_q     <= res_frame_q;
            rer_q       <= res_rer_q;
            state_q     <= S_IDLE;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign frame_o        = frame_q;
  assign rerandomized_o = rer_q;

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSETS  = 16;
  localparam int NWAYS  = 4;
  localparam int NCORES = 4;

  typedef struct packed {
    logic                         kind;
    logic [rstlb_pkg::TagW-1:0]   page;
    logic [rstlb_pkg::FrameW-1:0] frame;
    logic                         wr;
    logic [rstlb_pkg::CoreW-1:0]  core;
  } xlate_req_t;

  typedef struct packed {
    logic                         hit;
    logic [rstlb_pkg::FrameW-1:0] frame;
    logic                         rerand;
  } xlate_resp_t;

  localparam logic [15:0] MixA [16] = '{
    16'h0111, 16'h2220, 16'h4404, 16'h8088, 16'h1011, 16'h0222, 16'h4440, 16'h8808,
    16'h1101, 16'h2022, 16'h0444, 16'h8880, 16'h1110, 16'h2202, 16'h4044, 16'h0888};
  localparam logic [15:0] MixB [16] = '{
    16'h1110, 16'h2202, 16'h4044, 16'h0888, 16'h0111, 16'h2220, 16'h4404, 16'h8088,
    16'h1011, 16'h0222, 16'h4440, 16'h8808, 16'h1101, 16'h2022, 16'h0444, 16'h8880};
  localparam logic [3:0] Subst [16] = '{
    4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
    4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4};
  localparam logic [63:0] RoundC0 = 64'h13198a2e03707344;
  localparam logic [63:0] RoundC1 = 64'ha4093822299f31d0;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              kind_i;
  logic [51:0]       page_number_i;
  logic [35:0]       new_frame_i;
  logic              write_access_i;
  logic [1:0]        core_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              hit_o;
  logic [35:0]       frame_o;
  logic              rerandomized_o;
  logic              cfg_we_i;
  logic [1:0]        cfg_idx_i;
  logic [63:0]       cfg_data_i;

  randomized_skewed_tlb DUT (.*);

  // predictor state
  logic [63:0]                  key_q;
  logic [15:0]                  thr_q;
  logic                         shared_q;
  logic                         ent_valid [NSETS][NWAYS];
  logic [rstlb_pkg::TagW-1:0]   ent_tag   [NSETS][NWAYS];
  logic [rstlb_pkg::FrameW-1:0] ent_frame [NSETS][NWAYS];
  logic [1:0]                   ent_owner [NSETS][NWAYS];
  logic [2:0]                   ent_rank  [NSETS][NWAYS];
  logic [15:0]                  miss_cnt  [NCORES];
  logic [15:0]                  epoch     [NCORES];

  xlate_resp_t       pending_resp [$];
  xlate_req_t        page_pool [$];
  int                fail_cnt;
  int                tx_idle_pct;
  int                rx_stall_pct;
  int                hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("randomized_skewed_tlb: mismatch");
    $finish;
  end

  function automatic logic [15:0] gf_mix16(input logic [15:0] v, input logic use_b);
    logic [15:0] r;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      if (v[b]) begin
        r ^= use_b ? MixB[b] : MixA[b];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] mix_word(input logic [63:0] v);
    return {gf_mix16(v[63:48], 1'b0), gf_mix16(v[47:32], 1'b1),
            gf_mix16(v[31:16], 1'b1), gf_mix16(v[15:0], 1'b0)};
  endfunction

  function automatic logic [63:0] sub_word(input logic [63:0] v);
    logic [63:0] r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = Subst[v[4*n +: 4]];
    end
    return r;
  endfunction

  function automatic logic [63:0] scramble_page(input logic [rstlb_pkg::TagW-1:0] page,
                                                input logic [63:0] k);
    logic [63:0] x;
    x = {12'd0, page} ^ k ^ RoundC0;
    x = sub_word(mix_word(x));
    x = x ^ k ^ RoundC1;
    x = sub_word(mix_word(x));
    x = x ^ k;
    return mix_word(sub_word(x));
  endfunction

  function automatic void refresh_rank(input int s, input int w);
    logic [2:0] old;
    old = ent_rank[s][w];
    if (old != 1) begin
      ent_rank[s][w] = 3'd1;
      for (int i = 0; i < NWAYS; i++) begin
        if (i != w && ent_rank[s][i] < old && ent_rank[s][i] < NWAYS) begin
          ent_rank[s][i]++;
        end
      end
    end
  endfunction

  function automatic xlate_resp_t predict_translation(input xlate_req_t r);
    xlate_resp_t res;
    logic [63:0] ct;
    int idx [NWAYS];
    int victim;
    int best;
    res = '0;
    ct = scramble_page(r.page, key_q ^ {62'd0, r.core} ^ {48'd0, epoch[r.core]});
    for (int w = 0; w < NWAYS; w++) begin
      idx[w] = int'(ct[4*w +: 4]) & (NSETS - 1);
    end
    if (r.kind == 1'b0) begin
      for (int w = 0; w < NWAYS; w++) begin
        if (ent_valid[idx[w]][w] && ent_tag[idx[w]][w] == r.page &&
            (!shared_q || ent_owner[idx[w]][w] == r.core)) begin
          refresh_rank(idx[w], w);
          res.hit = 1'b1;
          res.frame = ent_frame[idx[w]][w];
          return res;
        end
      end
      miss_cnt[r.core]++;
      if (miss_cnt[r.core] >= thr_q) begin
        epoch[r.core]++;
        miss_cnt[r.core] = '0;
        res.rerand = 1'b1;
      end
    end else begin
      victim = NWAYS;
      for (int w = 0; w < NWAYS && victim == NWAYS; w++) begin
        if (!ent_valid[idx[w]][w]) victim = w;
      end
      for (int w = 0; w < NWAYS && victim == NWAYS; w++) begin
        if (ent_rank[idx[w]][w] == NWAYS) victim = w;
      end
      if (victim == NWAYS) begin
        best = 0;
        for (int w = 1; w < NWAYS; w++) begin
          if (ent_rank[idx[w]][w] > ent_rank[idx[best]][best]) best = w;
        end
        victim = best;
      end
      ent_valid[idx[victim]][victim] = 1'b1;
      ent_tag[idx[victim]][victim]   = r.page;
      ent_frame[idx[victim]][victim] = r.frame;
      ent_owner[idx[victim]][victim] = r.core;
      refresh_rank(idx[victim], victim);
    end
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    xlate_resp_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_resp.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result beat hit=%0b frame=%h", hit_o, frame_o);
      end else begin
        exp_r = pending_resp.pop_front();
        if (exp_r.hit !== hit_o || exp_r.frame !== frame_o || exp_r.rerand !== rerandomized_o) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("result beat: expected hit=%0b frame=%h rerand=%0b, got %0b %h %0b",
                     exp_r.hit, exp_r.frame, exp_r.rerand, hit_o, frame_o, rerandomized_o);
          end
        end
      end
    end
  end

  // receiver stalls and long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic send_request(input xlate_req_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= r.kind;
    page_number_i  <= r.page;
    new_frame_i    <= r.frame;
    write_access_i <= r.wr;
    core_i         <= r.core;
    do @(posedge clk_i); while (!in_ready_o);
    pending_resp.push_back(predict_translation(r));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input rstlb_pkg::cfg_idx_e idx, input logic [63:0] data);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rstlb_pkg::CFG_KEY:    key_q = data;
      rstlb_pkg::CFG_THR:    thr_q = data[15:0];
      rstlb_pkg::CFG_SHARED: shared_q = data[0];
      default: ;
    endcase
  endtask

  function automatic xlate_req_t make_req(input logic kind, input logic [51:0] page,
                                          input logic [35:0] frame, input logic wr,
                                          input logic [1:0] core);
    xlate_req_t r;
    r.kind = kind;
    r.page = page;
    r.frame = frame;
    r.wr = wr;
    r.core = core;
    return r;
  endfunction

  function automatic xlate_req_t random_req();
    xlate_req_t r;
    r = make_req(1'($urandom_range(1)), 52'({$urandom, $urandom}), 36'({$urandom, $urandom}),
                 1'($urandom_range(1)), 2'($urandom_range(NCORES - 1)));
    if (page_pool.size() != 0 && $urandom_range(99) < 75) begin
      r.page = page_pool[$urandom_range(page_pool.size() - 1)].page;
      if ($urandom_range(99) < 70) r.core = page_pool[$urandom_range(page_pool.size() - 1)].core;
    end
    if (r.kind) begin
      if (page_pool.size() >= 40) page_pool.delete($urandom_range(39));
      page_pool.push_back(r);
    end else if ($urandom_range(99) < 15) begin
      r.page = 52'({$urandom, $urandom});
    end
    return r;
  endfunction

  task automatic test_directed();
    send_request(make_req(1'b0, '0, '0, 1'b0, 2'd0));
    send_request(make_req(1'b1, '0, '1, 1'b1, 2'd0));
    send_request(make_req(1'b0, '0, '1, 1'b0, 2'd0));
    send_request(make_req(1'b0, '0, '0, 1'b0, 2'd0));
    send_request(make_req(1'b1, '1, '0, 1'b0, 2'd3));
    send_request(make_req(1'b0, '1, '0, 1'b1, 2'd3));
    send_request(make_req(1'b0, '1, '0, 1'b0, 2'd1));
    send_request(make_req(1'b1, 52'h5555555555555, 36'haaaaaaaaa, 1'b1, 2'd2));
    send_request(make_req(1'b1, 52'haaaaaaaaaaaaa, 36'h555555555, 1'b0, 2'd1));
    send_request(make_req(1'b0, 52'h5555555555555, '0, 1'b0, 2'd2));
    write_reg(rstlb_pkg::CFG_SHARED, 64'd1);
    send_request(make_req(1'b0, '1, '0, 1'b0, 2'd1));
    send_request(make_req(1'b0, '1, '0, 1'b0, 2'd3));
    write_reg(rstlb_pkg::CFG_THR, 64'd1);
    send_request(make_req(1'b0, 52'h1234, '0, 1'b0, 2'd2));
    send_request(make_req(1'b0, 52'h5555555555555, '0, 1'b0, 2'd2));
    write_reg(rstlb_pkg::CFG_THR, 64'd0);
    send_request(make_req(1'b0, 52'h99, '0, 1'b0, 2'd1));
    write_reg(rstlb_pkg::CFG_THR, 64'd65535);
    for (int i = 0; i < 4; i++) send_request(make_req(1'b0, 52'(52'h77 + i), '0, 1'b0, 2'd0));
    // threshold dropped below current count
    write_reg(rstlb_pkg::CFG_THR, 64'd2);
    send_request(make_req(1'b0, 52'h88, '0, 1'b0, 2'd0));
    write_reg(rstlb_pkg::CFG_SHARED, 64'd0);
    write_reg(rstlb_pkg::CFG_KEY, 64'd0);
    send_request(make_req(1'b0, '0, '0, 1'b0, 2'd0));
    write_reg(rstlb_pkg::CFG_KEY, '1);
    send_request(make_req(1'b1, 52'h42, 36'h42, 1'b0, 2'd0));
    send_request(make_req(1'b0, 52'h42, '0, 1'b0, 2'd0));
  endtask

  task automatic test_random(input int n, input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int i = 0; i < n; i++) send_request(random_req());
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) send_request(random_req());
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    page_number_i = '0;
    new_frame_i = '0;
    write_access_i = 1'b0;
    core_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rstlb_pkg::CFG_KEY;
    cfg_data_i = '0;
    fail_cnt = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_cycles = 0;
    key_q = rstlb_pkg::KeyRst;
    thr_q = rstlb_pkg::ThrRst;
    shared_q = 1'b0;
    for (int s = 0; s < NSETS; s++) begin
      for (int w = 0; w < NWAYS; w++) begin
        ent_valid[s][w] = 1'b0;
        ent_rank[s][w] = 3'(NWAYS);
      end
    end
    for (int c = 0; c < NCORES; c++) begin
      miss_cnt[c] = '0;
      epoch[c] = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    write_reg(rstlb_pkg::CFG_THR, 64'd16);
    test_random(200, 0, 0);
    write_reg(rstlb_pkg::CFG_KEY, {$urandom, $urandom});
    write_reg(rstlb_pkg::CFG_THR, 64'($urandom_range(8, 1)));
    test_random(200, 57, 0);
    write_reg(rstlb_pkg::CFG_SHARED, 64'd1);
    test_random(200, 0, 57);
    test_backpressure();
    write_reg(rstlb_pkg::CFG_SHARED, 64'd0);
    write_reg(rstlb_pkg::CFG_THR, 64'd65535);
    test_random(200, 33, 33);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("randomized_skewed_tlb: match");
    end else begin
      $display("randomized_skewed_tlb: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rstlb_pkg.sv
sv/rstlb_cipher.sv
sv/rstlb_way.sv
sv/randomized_skewed_tlb.sv
verif/tb_top.sv
